>>> src/tses_pkg.sv
`default_nettype none

package tses_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam int COORD_W = 10;
  localparam int END_W   = 11;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic               vertical;
    logic [COORD_W-1:0] fixed_coord;
    logic [COORD_W-1:0] seg_start;
    logic [END_W-1:0]   seg_end;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

>>> src/tses_res_fifo.sv
`default_nettype none

module tses_res_fifo
  import tses_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] push_cnt,
  input  wire res_t       d0,
  input  wire res_t       d1,
  output logic            has_room,
  output logic            out_valid,
  input  wire logic       out_ready,
  output res_t            head
);

  res_t                 slots [FIFO_DEPTH];
  logic [FIFO_PW-1:0]   wr_ptr;
  logic [FIFO_PW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = slots[rd_ptr];
  // room for a tile that yields two results
  assign has_room  = (count <= FIFO_CW'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      slots[wr_ptr] <= d0;
    end
    if (push_cnt == 2'd2) begin
      slots[wr_ptr + FIFO_PW'(1)] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PW'(push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PW'(1);
      end
      count <= count + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
    end
  end

endmodule

`default_nettype wire

>>> src/tile_edge_segment_extractor.sv
`default_nettype none

// Takes one tile flag per cycle in raster order and reports closed edge runs
// (horizontal runs along a row, vertical runs down a column), split at region
// and grid boundaries. A tile is accepted every cycle while the result queue
// has room for two results; results leave at one per cycle while out_ready is
// high, so a tile that closes both a horizontal and a vertical run gives two
// results. The per-column state (tile above, open vertical run and its start
// row) sits in one memory, read through a register ahead of the next column
// and written back as the tile is taken, with a bypass when the same column
// comes up again. Row 0 never looks at that memory, so no clearing pass follows
// reset. A write to the grid width or height register restarts the scan.
module tile_edge_segment_extractor
  import tses_pkg::*;
#(
  parameter int REGION     = 16,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  tile_solid,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       vertical,
  output logic [COORD_W-1:0]         fixed_coord,
  output logic [COORD_W-1:0]         seg_start,
  output logic [END_W-1:0]           seg_end,
  output logic                       last
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YAW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW  = $clog2(MAX_WIDTH + 1) + 1;
  localparam int YW  = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int RW  = (REGION > 1) ? $clog2(REGION) : 1;
  localparam int EW  = YAW + 2;

  function automatic int eff(input logic [CFG_DATA_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  logic [XW-1:0]  w_eff;
  logic [YW-1:0]  h_eff;
  logic [AW-1:0]  col;
  logic [YAW-1:0] row;
  logic [RW-1:0]  hcnt;
  logic [RW-1:0]  vcnt;
  logic           left_solid;
  logic           ha;
  logic [AW-1:0]  hb;

  logic [EW-1:0]  mem [MAX_WIDTH];
  logic [EW-1:0]  mem_q;
  logic [EW-1:0]  fwd_q;
  logic           fwd;
  logic [EW-1:0]  entry;
  logic [EW-1:0]  wdata;
  logic [AW-1:0]  rd_addr;

  logic           acc;
  logic           restart;
  logic           x_end, y_end, hreg_end, vreg_end;
  logic [AW-1:0]  next_col;
  logic           above, left, hedge, vedge;
  logic           va, va_mid, va_next;
  logic [YAW-1:0] vb, vb_mid;
  logic           ha_mid, ha_next;
  logic [AW-1:0]  hb_mid;
  logic           h_emit, v_emit;
  logic [XW-1:0]  h_end;
  logic [YW-1:0]  v_end;
  res_t           h_res, v_res;
  logic [1:0]     push_cnt;
  logic           has_room;
  res_t           head;

  assign acc     = in_valid && in_ready;
  assign in_ready = has_room;
  assign restart = cfg_we && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

  assign x_end    = (XW'(col) + XW'(1) == w_eff);
  assign y_end    = (YW'(row) + YW'(1) == h_eff);
  assign hreg_end = (hcnt == RW'(REGION - 1));
  assign vreg_end = (vcnt == RW'(REGION - 1));
  assign next_col = x_end ? '0 : col + AW'(1);

  assign entry = fwd ? fwd_q : mem_q;
  assign above = (row == '0) ? 1'b1 : entry[EW-1];
  assign va    = (row == '0) ? 1'b0 : entry[EW-2];
  assign vb    = entry[YAW-1:0];
  assign left  = (col == '0) ? 1'b1 : left_solid;
  assign hedge = (tile_solid != above);
  assign vedge = (tile_solid != left);

  always_comb begin
    ha_mid = ha;
    hb_mid = hb;
    h_emit = 1'b0;
    h_end  = XW'(col);
    if (hedge && !ha) begin
      ha_mid = 1'b1;
      hb_mid = col;
    end else if (!hedge && ha) begin
      h_emit = 1'b1;
      ha_mid = 1'b0;
    end
    ha_next = ha_mid;
    if (ha_mid && (hreg_end || x_end)) begin
      h_emit  = 1'b1;
      h_end   = XW'(col) + XW'(1);
      ha_next = 1'b0;
    end
  end

  always_comb begin
    va_mid = va;
    vb_mid = vb;
    v_emit = 1'b0;
    v_end  = YW'(row);
    if (vedge && !va) begin
      va_mid = 1'b1;
      vb_mid = row;
    end else if (!vedge && va) begin
      v_emit = 1'b1;
      va_mid = 1'b0;
    end
    va_next = va_mid;
    if (va_mid && (vreg_end || y_end)) begin
      v_emit  = 1'b1;
      v_end   = YW'(row) + YW'(1);
      va_next = 1'b0;
    end
  end

  assign wdata   = {tile_solid, va_next, vb_mid};
  assign rd_addr = acc ? next_col : col;

  always_ff @(posedge clk) begin
    if (acc) begin
      mem[col] <= wdata;
    end
    mem_q <= mem[rd_addr];
    fwd_q <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= XW'(eff(CFG_DATA_W'(1024), MAX_WIDTH));
      h_eff <= YW'(eff(CFG_DATA_W'(1024), MAX_HEIGHT));
    end else if (cfg_we && cfg_index == REG_GRID_WIDTH) begin
      w_eff <= XW'(eff(cfg_data, MAX_WIDTH));
    end else if (cfg_we && cfg_index == REG_GRID_HEIGHT) begin
      h_eff <= YW'(eff(cfg_data, MAX_HEIGHT));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col        <= '0;
      row        <= '0;
      hcnt       <= '0;
      vcnt       <= '0;
      left_solid <= 1'b1;
      ha         <= 1'b0;
      fwd        <= 1'b0;
    end else begin
      fwd <= acc && (next_col == col);
      if (acc) begin
        left_solid <= tile_solid;
        ha         <= ha_next;
        col        <= next_col;
        if (x_end) begin
          hcnt <= '0;
          if (y_end) begin
            row  <= '0;
            vcnt <= '0;
          end else begin
            row  <= row + YAW'(1);
            vcnt <= vreg_end ? '0 : vcnt + RW'(1);
          end
        end else begin
          hcnt <= hreg_end ? '0 : hcnt + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      hb <= hb_mid;
    end
  end

  always_comb begin
    h_res.vertical    = 1'b0;
    h_res.fixed_coord = COORD_W'(row);
    h_res.seg_start   = COORD_W'(hb_mid);
    h_res.seg_end     = END_W'(h_end);
    h_res.last        = !v_emit;
    v_res.vertical    = 1'b1;
    v_res.fixed_coord = COORD_W'(col);
    v_res.seg_start   = COORD_W'(vb_mid);
    v_res.seg_end     = END_W'(v_end);
    v_res.last        = 1'b1;
  end

  assign push_cnt = acc ? (2'(h_emit) + 2'(v_emit)) : 2'd0;

  tses_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .d0        (h_emit ? h_res : v_res),
    .d1        (v_res),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign vertical    = head.vertical;
  assign fixed_coord = head.fixed_coord;
  assign seg_start   = head.seg_start;
  assign seg_end     = head.seg_end;
  assign last        = head.last;

endmodule

`default_nettype wire

>>> verif/tses_seg_checker.sv
module tses_seg_checker
  import tses_pkg::*;
#(
  parameter int REGION     = 16,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic                  tile_solid,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic                  vertical,
  input  wire logic [COORD_W-1:0]    fixed_coord,
  input  wire logic [COORD_W-1:0]    seg_start,
  input  wire logic [END_W-1:0]      seg_end,
  input  wire logic                  last,
  output int                         errors,
  output int                         pending
);

  logic [CFG_DATA_W-1:0] grid_w;
  logic [CFG_DATA_W-1:0] grid_h;

  bit                row_above [MAX_WIDTH];
  bit                left_solid;
  int                col_pos;
  int                row_pos;
  bit                horiz_open;
  int                horiz_from;
  bit                vert_open [MAX_WIDTH];
  int                vert_from [MAX_WIDTH];

  res_t              segs_due [$];

  function automatic int eff_size(input logic [CFG_DATA_W-1:0] v, input int maxv);
    if (v == '0)
      return 1;
    if (int'(v) > maxv)
      return maxv;
    return int'(v);
  endfunction

  function automatic res_t make_seg(input bit vert, input int fixed, input int from,
                                    input int upto);
    res_t r;
    r.vertical    = vert;
    r.fixed_coord = fixed[COORD_W-1:0];
    r.seg_start   = from[COORD_W-1:0];
    r.seg_end     = upto[END_W-1:0];
    r.last        = 1'b0;
    return r;
  endfunction

  task automatic clear_scan();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_above[i] = 1'b1;
      vert_open[i] = 1'b0;
      vert_from[i] = 0;
    end
    left_solid = 1'b1;
    col_pos    = 0;
    row_pos    = 0;
    horiz_open = 1'b0;
    horiz_from = 0;
  endtask

  task automatic predict_tile(input bit s);
    int   w, h, x, y, n;
    bit   above, left_v, hedge, vedge;
    res_t segs [2];
    w = eff_size(grid_w, MAX_WIDTH);
    h = eff_size(grid_h, MAX_HEIGHT);
    x = col_pos;
    y = row_pos;
    n = 0;
    if (x >= w || y >= h) begin
      x = 0;
      y = 0;
    end
    above  = (y == 0) ? 1'b1 : row_above[x];
    left_v = (x == 0) ? 1'b1 : left_solid;
    hedge  = (s != above);
    vedge  = (s != left_v);

    if (hedge && !horiz_open) begin
      horiz_open = 1'b1;
      horiz_from = x;
    end else if (!hedge && horiz_open) begin
      segs[n] = make_seg(1'b0, y, horiz_from, x);
      n++;
      horiz_open = 1'b0;
    end
    if (horiz_open && (((x + 1) % REGION) == 0 || x + 1 == w)) begin
      segs[n] = make_seg(1'b0, y, horiz_from, x + 1);
      n++;
      horiz_open = 1'b0;
    end

    if (vedge && !vert_open[x]) begin
      vert_open[x] = 1'b1;
      vert_from[x] = y;
    end else if (!vedge && vert_open[x]) begin
      segs[n] = make_seg(1'b1, x, vert_from[x], y);
      n++;
      vert_open[x] = 1'b0;
    end
    if (vert_open[x] && (((y + 1) % REGION) == 0 || y + 1 == h)) begin
      segs[n] = make_seg(1'b1, x, vert_from[x], y + 1);
      n++;
      vert_open[x] = 1'b0;
    end

    row_above[x] = s;
    left_solid   = s;
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end

    if (n > 0)
      segs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++)
      segs_due.insert(segs_due.size(), segs[i]);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      grid_w = CFG_DATA_W'(1024);
      grid_h = CFG_DATA_W'(1024);
      clear_scan();
      segs_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_GRID_WIDTH) begin
          grid_w = cfg_data;
          clear_scan();
        end else if (cfg_index == REG_GRID_HEIGHT) begin
          grid_h = cfg_data;
          clear_scan();
        end
      end
      if (in_valid && in_ready)
        predict_tile(tile_solid);
      if (out_valid && out_ready) begin
        got.vertical    = vertical;
        got.fixed_coord = fixed_coord;
        got.seg_start   = seg_start;
        got.seg_end     = seg_end;
        got.last        = last;
        if (segs_due.size() == 0) begin
          if (errors < 10)
            $display("unexpected segment: v=%0d fixed=%0d start=%0d end=%0d last=%0d",
                     got.vertical, got.fixed_coord, got.seg_start, got.seg_end, got.last);
          errors++;
        end else begin
          want = segs_due.pop_front();
          if (got.vertical !== want.vertical || got.fixed_coord !== want.fixed_coord ||
              got.seg_start !== want.seg_start || got.seg_end !== want.seg_end ||
              got.last !== want.last) begin
            if (errors < 10) begin
              $display("segment mismatch: exp v=%0d fixed=%0d start=%0d end=%0d last=%0d",
                       want.vertical, want.fixed_coord, want.seg_start, want.seg_end,
                       want.last);
              $display("                  got v=%0d fixed=%0d start=%0d end=%0d last=%0d",
                       got.vertical, got.fixed_coord, got.seg_start, got.seg_end,
                       got.last);
            end
            errors++;
          end
        end
      end
    end
    pending = segs_due.size();
  end

endmodule

>>> verif/tile_edge_segment_extractor_tb.sv
module tile_edge_segment_extractor_tb;
  import tses_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 24;
  localparam int IDLE_PCT     = 37;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  tile_solid = 1'b0;
  logic                  out_ready  = 1'b1;
  logic                  in_ready;
  logic                  out_valid;
  logic                  vertical;
  logic [COORD_W-1:0]    fixed_coord;
  logic [COORD_W-1:0]    seg_start;
  logic [END_W-1:0]      seg_end;
  logic                  last;

  int errors;
  int pending;
  int stall_cycles = 0;
  bit in_idle      = 1'b0;
  bit out_idle     = 1'b0;
  int solid_pct    = 50;
  int stick_pct    = 50;
  bit cur_tile     = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tile_edge_segment_extractor dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .tile_solid(tile_solid),
    .out_valid(out_valid), .out_ready(out_ready), .vertical(vertical),
    .fixed_coord(fixed_coord), .seg_start(seg_start), .seg_end(seg_end), .last(last)
  );

  tses_seg_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .tile_solid(tile_solid),
    .out_valid(out_valid), .out_ready(out_ready), .vertical(vertical),
    .fixed_coord(fixed_coord), .seg_start(seg_start), .seg_end(seg_end), .last(last),
    .errors(errors), .pending(pending)
  );

  always @(negedge clk)
    out_ready = !out_idle || ($urandom_range(0, 99) >= IDLE_PCT);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic bit next_tile();
    if ($urandom_range(0, 99) >= stick_pct)
      cur_tile = ($urandom_range(0, 99) < solid_pct);
    return cur_tile;
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 5))
      0:       return 1;
      1:       return 16;
      2:       return 17;
      3:       return $urandom_range(1, 8);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  task automatic send_tile(input bit s);
    @(negedge clk);
    while (in_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    tile_solid = s;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic run_tiles(input int count);
    for (int i = 0; i < count; i++)
      send_tile(next_tile());
  endtask

  initial begin
    logic [19:0] first_row;
    logic [3:0]  after_ignored;
    int          w, h, n, small_items;
    first_row     = 20'b11000000000000011001;
    after_ignored = 4'b1010;
    small_items   = 0;

    repeat (2) @(negedge clk);
    rst = 1'b0;

    // row 0 of the reset-size grid: runs closed by a solid tile and at a region edge
    for (int i = 0; i < 20; i++)
      send_tile(first_row[i]);
    // unknown indexes must not restart the scan
    write_reg(2'd2, 11'h7FF);
    write_reg(2'd3, 11'd5);
    for (int i = 0; i < 4; i++)
      send_tile(after_ignored[i]);

    // out-of-range sizes: full-width single row, wrapping, no idling
    write_reg(REG_GRID_WIDTH, 11'h7FF);
    write_reg(REG_GRID_HEIGHT, 11'd0);
    solid_pct = 50;
    stick_pct = 60;
    for (int i = 0; i < 1034; i++) begin
      if (i == 500) begin
        wait_drained();
      end
      send_tile(next_tile());
    end

    // single column, height clamped to max
    in_idle  = 1'b1;
    out_idle = 1'b1;
    write_reg(REG_GRID_WIDTH, 11'd0);
    write_reg(REG_GRID_HEIGHT, 11'd1025);
    stick_pct = 80;
    run_tiles(60);

    write_reg(REG_GRID_WIDTH, 11'd1024);
    write_reg(REG_GRID_HEIGHT, 11'd1024);
    stick_pct = 30;
    run_tiles(30);

    while (small_items < 800) begin
      w = pick_size();
      h = pick_size();
      write_reg(REG_GRID_WIDTH, w[CFG_DATA_W-1:0]);
      write_reg(REG_GRID_HEIGHT, h[CFG_DATA_W-1:0]);
      case ($urandom_range(0, 4))
        0:       solid_pct = 0;
        1:       solid_pct = 100;
        2:       solid_pct = 10;
        3:       solid_pct = 90;
        default: solid_pct = 50;
      endcase
      stick_pct = $urandom_range(0, 90);
      in_idle   = ($urandom_range(0, 3) != 0);
      out_idle  = ($urandom_range(0, 3) != 0);
      n = w * h * 2 + $urandom_range(0, w);
      if (n > 200)
        n = 200;
      run_tiles(n);
      small_items += n;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
